/* hdl/ngr_pkg.sv */
// Package for the n-gram record parser: parse phases, result status codes,
// character constants and the Latin-1 letter fold table.
// Used by ngr_fold, ngr_core and ngram_record_parser; depends on nothing.
`timescale 1ns / 1ps

package ngr_pkg;

  localparam int unsigned INDEX_W  = 19;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned TOTAL_W  = 4;
  localparam int unsigned ORDER_W  = 3;
  localparam int unsigned CP_W     = 16;

  typedef enum logic [2:0] {
    PH_LEAD         = 3'd0,
    PH_TOKEN        = 3'd1,
    PH_GAP          = 3'd2,
    PH_SIGN         = 3'd3,
    PH_DIGITS       = 3'd4,
    PH_DONE_NOCOUNT = 3'd5,
    PH_DONE_COUNT   = 3'd6
  } ngr_phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TOKEN   = 3'd1,
    ST_NOCOUNT = 3'd2,
    ST_FOLD    = 3'd3,
    ST_ORDER   = 3'd4
  } ngr_status_e;

  typedef struct packed {
    ngr_status_e            status;
    logic                   count_clamped;
    logic [TOTAL_W-1:0]     letters;
    logic [INDEX_W-1:0]     gram_index;
    logic [COUNT_W-1:0]     count;
  } ngr_result_t;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_PLUS  = 8'h2B;
  localparam logic [7:0] DIGIT_0    = 8'h30;
  localparam logic [7:0] DIGIT_9    = 8'h39;

  localparam logic [CP_W-1:0] CP_LOWER_A = 16'h0061;
  localparam logic [CP_W-1:0] CP_LOWER_Z = 16'h007A;
  localparam logic [CP_W-1:0] CP_CASE    = 16'h0020;
  localparam logic [CP_W-1:0] CP_UPPER_A = 16'h0041;
  localparam logic [CP_W-1:0] CP_UPPER_Z = 16'h005A;
  localparam logic [CP_W-1:0] CP_LAT1_LO = 16'h00C0;
  localparam logic [CP_W-1:0] CP_LAT1_HI = 16'h00FF;
  localparam logic [CP_W-1:0] CP_OE      = 16'h0152;
  localparam logic [CP_W-1:0] CP_Y_DIAER = 16'h0178;
  localparam logic [CP_W-1:0] CP_A_OGON  = 16'h0104;
  localparam logic [CP_W-1:0] CP_C_ACUTE = 16'h0106;
  localparam logic [CP_W-1:0] CP_E_OGON  = 16'h0118;
  localparam logic [CP_W-1:0] CP_L_STROK = 16'h0141;
  localparam logic [CP_W-1:0] CP_N_ACUTE = 16'h0143;
  localparam logic [CP_W-1:0] CP_S_ACUTE = 16'h015A;
  localparam logic [CP_W-1:0] CP_Z_ACUTE = 16'h0179;

  localparam logic [LETTER_W-1:0] LTR_A = 5'd0;
  localparam logic [LETTER_W-1:0] LTR_C = 5'd2;
  localparam logic [LETTER_W-1:0] LTR_D = 5'd3;
  localparam logic [LETTER_W-1:0] LTR_E = 5'd4;
  localparam logic [LETTER_W-1:0] LTR_I = 5'd8;
  localparam logic [LETTER_W-1:0] LTR_L = 5'd11;
  localparam logic [LETTER_W-1:0] LTR_N = 5'd13;
  localparam logic [LETTER_W-1:0] LTR_O = 5'd14;
  localparam logic [LETTER_W-1:0] LTR_S = 5'd18;
  localparam logic [LETTER_W-1:0] LTR_T = 5'd19;
  localparam logic [LETTER_W-1:0] LTR_U = 5'd20;
  localparam logic [LETTER_W-1:0] LTR_Y = 5'd24;
  localparam logic [LETTER_W-1:0] LTR_Z = 5'd25;

  // The multiplication and division signs of Latin-1 have no base letter.
  localparam logic [4:0] LATIN1_NONE = 5'd23;

  function automatic logic [LETTER_W-1:0] latin1_letter(input logic [5:0] idx);
    logic [LETTER_W-1:0] ltr;
    ltr = LTR_A;
    unique case (idx[4:0]) inside
      [5'd0:5'd6]:   ltr = LTR_A;
      5'd7:          ltr = LTR_C;
      [5'd8:5'd11]:  ltr = LTR_E;
      [5'd12:5'd15]: ltr = LTR_I;
      5'd16:         ltr = LTR_D;
      5'd17:         ltr = LTR_N;
      [5'd18:5'd22]: ltr = LTR_O;
      5'd23:         ltr = LTR_A;
      5'd24:         ltr = LTR_O;
      [5'd25:5'd28]: ltr = LTR_U;
      5'd29:         ltr = LTR_Y;
      5'd30:         ltr = LTR_T;
      5'd31:         ltr = idx[5] ? LTR_Y : LTR_S;
      default:       ltr = LTR_A;
    endcase
    return ltr;
  endfunction

endpackage

/* hdl/ngr_fold.sv */
// Folds one decoded code point to a letter number 0 to 25, or flags it.
// Depends on ngr_pkg.
`timescale 1ns / 1ps

module ngr_fold (
  input  logic [ngr_pkg::CP_W-1:0]     cp_i,
  output logic                         ok_o,
  output logic [ngr_pkg::LETTER_W-1:0] letter_o
);

  logic [ngr_pkg::CP_W-1:0] upper;
  logic [ngr_pkg::CP_W-1:0] rel;

  always_comb begin
    upper    = cp_i;
    ok_o     = 1'b1;
    letter_o = ngr_pkg::LTR_A;
    if (cp_i >= ngr_pkg::CP_LOWER_A && cp_i <= ngr_pkg::CP_LOWER_Z) begin
      upper = cp_i - ngr_pkg::CP_CASE;
    end
    rel = upper - ngr_pkg::CP_UPPER_A;
    if (upper >= ngr_pkg::CP_UPPER_A && upper <= ngr_pkg::CP_UPPER_Z) begin
      letter_o = rel[ngr_pkg::LETTER_W-1:0];
    end else if (upper >= ngr_pkg::CP_LAT1_LO && upper <= ngr_pkg::CP_LAT1_HI) begin
      letter_o = ngr_pkg::latin1_letter(upper[5:0]);
      ok_o     = (upper[4:0] != ngr_pkg::LATIN1_NONE);
    end else begin
      unique case (upper)
        ngr_pkg::CP_OE, ngr_pkg::CP_OE + 16'd1:
          letter_o = ngr_pkg::LTR_O;
        ngr_pkg::CP_Y_DIAER:
          letter_o = ngr_pkg::LTR_Y;
        ngr_pkg::CP_A_OGON, ngr_pkg::CP_A_OGON + 16'd1:
          letter_o = ngr_pkg::LTR_A;
        ngr_pkg::CP_C_ACUTE, ngr_pkg::CP_C_ACUTE + 16'd1:
          letter_o = ngr_pkg::LTR_C;
        ngr_pkg::CP_E_OGON, ngr_pkg::CP_E_OGON + 16'd1:
          letter_o = ngr_pkg::LTR_E;
        ngr_pkg::CP_L_STROK, ngr_pkg::CP_L_STROK + 16'd1:
          letter_o = ngr_pkg::LTR_L;
        ngr_pkg::CP_N_ACUTE, ngr_pkg::CP_N_ACUTE + 16'd1:
          letter_o = ngr_pkg::LTR_N;
        ngr_pkg::CP_S_ACUTE, ngr_pkg::CP_S_ACUTE + 16'd1:
          letter_o = ngr_pkg::LTR_S;
        ngr_pkg::CP_Z_ACUTE, ngr_pkg::CP_Z_ACUTE + 16'd1,
        ngr_pkg::CP_Z_ACUTE + 16'd2, ngr_pkg::CP_Z_ACUTE + 16'd3:
          letter_o = ngr_pkg::LTR_Z;
        default:
          ok_o = 1'b0;
      endcase
    end
  end

endmodule

/* hdl/ngr_core.sv */
// Parser state registers and the combinational update for one record byte,
// with the end-of-record result. Depends on ngr_pkg and ngr_fold.
`timescale 1ns / 1ps

module ngr_core #(
  parameter int unsigned MAX_ORDER       = 4,
  parameter int unsigned MAX_TOKEN_BYTES = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    byte_i,
  input  logic                          eor_i,
  input  logic [ngr_pkg::ORDER_W-1:0]   gram_order_i,
  output ngr_pkg::ngr_result_t          result_o
);

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_BYTES + 2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_BYTES);
  localparam logic [ngr_pkg::TOTAL_W-1:0] TOTAL_SAT = '1;

  ngr_pkg::ngr_phase_e              ph_q, ph_d;
  logic [LEN_W-1:0]                 len_q, len_d;
  logic [1:0]                       pend_q, pend_d;
  logic [ngr_pkg::CP_W-1:0]         cp_q, cp_d;
  logic [ngr_pkg::INDEX_W-1:0]      idx_q, idx_d;
  logic [ngr_pkg::TOTAL_W-1:0]      total_q, total_d;
  logic                             failed_q, failed_d;
  logic [ngr_pkg::COUNT_W-1:0]      count_q, count_d;
  logic                             ovf_q, ovf_d;

  logic                             is_space, is_digit, is_nul;
  logic                             do_token, do_digit, decode_en, add_en;
  logic [ngr_pkg::CP_W-1:0]         cont_cp, fold_cp;
  logic                             fold_ok;
  logic [ngr_pkg::LETTER_W-1:0]     fold_letter;
  logic [ngr_pkg::COUNT_W+3:0]      count_next;
  logic                             failed_fin;
  ngr_pkg::ngr_status_e             status;

  assign is_nul   = (byte_i == ngr_pkg::BYTE_NUL);
  assign is_space = (byte_i == ngr_pkg::BYTE_SPACE) ||
                    (byte_i >= ngr_pkg::BYTE_TAB && byte_i <= ngr_pkg::BYTE_CR);
  assign is_digit = (byte_i >= ngr_pkg::DIGIT_0) && (byte_i <= ngr_pkg::DIGIT_9);

  assign cont_cp = {cp_q[ngr_pkg::CP_W-7:0], byte_i[5:0]};
  assign fold_cp = (pend_q == 2'd0) ? {8'h00, byte_i} : cont_cp;

  ngr_fold u_fold (
    .cp_i     (fold_cp),
    .ok_o     (fold_ok),
    .letter_o (fold_letter)
  );

  assign count_next = ({4'h0, count_q} << 3) + ({4'h0, count_q} << 1) +
                      {{(ngr_pkg::COUNT_W){1'b0}}, byte_i[3:0]};

  always_comb begin
    ph_d      = ph_q;
    len_d     = len_q;
    pend_d    = pend_q;
    cp_d      = cp_q;
    idx_d     = idx_q;
    total_d   = total_q;
    failed_d  = failed_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    do_token  = 1'b0;
    do_digit  = 1'b0;
    decode_en = 1'b0;
    add_en    = 1'b0;

    unique case (ph_q)
      ngr_pkg::PH_LEAD: begin
        if (is_nul) begin
          ph_d = ngr_pkg::PH_DONE_NOCOUNT;
        end else if (!is_space) begin
          do_token = 1'b1;
          ph_d     = ngr_pkg::PH_TOKEN;
        end
      end
      ngr_pkg::PH_TOKEN: begin
        if (is_nul) begin
          ph_d = ngr_pkg::PH_DONE_NOCOUNT;
        end else if (is_space) begin
          ph_d = ngr_pkg::PH_GAP;
        end else begin
          do_token = 1'b1;
        end
      end
      ngr_pkg::PH_GAP: begin
        if (!is_space) begin
          if (byte_i == ngr_pkg::BYTE_PLUS) begin
            ph_d = ngr_pkg::PH_SIGN;
          end else if (is_digit) begin
            do_digit = 1'b1;
            ph_d     = ngr_pkg::PH_DIGITS;
          end else begin
            ph_d = ngr_pkg::PH_DONE_NOCOUNT;
          end
        end
      end
      ngr_pkg::PH_SIGN: begin
        if (is_digit) begin
          do_digit = 1'b1;
          ph_d     = ngr_pkg::PH_DIGITS;
        end else begin
          ph_d = ngr_pkg::PH_DONE_NOCOUNT;
        end
      end
      ngr_pkg::PH_DIGITS: begin
        if (is_digit) begin
          do_digit = 1'b1;
        end else begin
          ph_d = ngr_pkg::PH_DONE_COUNT;
        end
      end
      ngr_pkg::PH_DONE_NOCOUNT, ngr_pkg::PH_DONE_COUNT: begin
      end
      default: begin
      end
    endcase

    if (do_token) begin
      if (len_q <= LEN_MAX) begin
        len_d = len_q + LEN_W'(1);
      end
      decode_en = (len_q < LEN_MAX);
    end

    if (decode_en && !failed_q) begin
      if (pend_q == 2'd0) begin
        if (!byte_i[7]) begin
          add_en = 1'b1;
        end else if (byte_i[7:5] == 3'b110) begin
          cp_d   = {11'h000, byte_i[4:0]};
          pend_d = 2'd1;
        end else if (byte_i[7:4] == 4'b1110) begin
          cp_d   = {12'h000, byte_i[3:0]};
          pend_d = 2'd2;
        end else begin
          failed_d = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        failed_d = 1'b1;
      end else begin
        cp_d   = cont_cp;
        pend_d = pend_q - 2'd1;
        add_en = (pend_q == 2'd1);
      end
    end

    if (add_en) begin
      if (!fold_ok) begin
        failed_d = 1'b1;
      end else begin
        idx_d = ngr_pkg::INDEX_W'(idx_q * 5'd26) +
                {{(ngr_pkg::INDEX_W-ngr_pkg::LETTER_W){1'b0}}, fold_letter};
        if (total_q != TOTAL_SAT) begin
          total_d = total_q + ngr_pkg::TOTAL_W'(1);
        end
      end
    end

    if (do_digit && !ovf_q) begin
      if (count_next[ngr_pkg::COUNT_W+3:ngr_pkg::COUNT_W] != 4'h0) begin
        count_d = '1;
        ovf_d   = 1'b1;
      end else begin
        count_d = count_next[ngr_pkg::COUNT_W-1:0];
      end
    end
  end

  assign failed_fin = failed_d || (pend_d != 2'd0);

  always_comb begin
    if (len_d == '0 || len_d > LEN_MAX) begin
      status = ngr_pkg::ST_TOKEN;
    end else if (ph_d != ngr_pkg::PH_DIGITS && ph_d != ngr_pkg::PH_DONE_COUNT) begin
      status = ngr_pkg::ST_NOCOUNT;
    end else if (failed_fin) begin
      status = ngr_pkg::ST_FOLD;
    end else if (gram_order_i > ngr_pkg::ORDER_W'(MAX_ORDER) ||
                 ngr_pkg::TOTAL_W'(gram_order_i) != total_d) begin
      status = ngr_pkg::ST_ORDER;
    end else begin
      status = ngr_pkg::ST_OK;
    end
    result_o.status        = status;
    result_o.count_clamped = ovf_d && (status == ngr_pkg::ST_OK ||
                             status == ngr_pkg::ST_FOLD || status == ngr_pkg::ST_ORDER);
    result_o.letters       = (status == ngr_pkg::ST_OK || status == ngr_pkg::ST_ORDER) ?
                             total_d : '0;
    result_o.gram_index    = (status == ngr_pkg::ST_OK) ? idx_d : '0;
    result_o.count         = (status == ngr_pkg::ST_OK || status == ngr_pkg::ST_FOLD ||
                             status == ngr_pkg::ST_ORDER) ? count_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= ngr_pkg::PH_LEAD;
      len_q    <= '0;
      pend_q   <= '0;
      cp_q     <= '0;
      idx_q    <= '0;
      total_q  <= '0;
      failed_q <= 1'b0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (step_i) begin
      if (eor_i) begin
        ph_q     <= ngr_pkg::PH_LEAD;
        len_q    <= '0;
        pend_q   <= '0;
        cp_q     <= '0;
        idx_q    <= '0;
        total_q  <= '0;
        failed_q <= 1'b0;
        count_q  <= '0;
        ovf_q    <= 1'b0;
      end else begin
        ph_q     <= ph_d;
        len_q    <= len_d;
        pend_q   <= pend_d;
        cp_q     <= cp_d;
        idx_q    <= idx_d;
        total_q  <= total_d;
        failed_q <= failed_d;
        count_q  <= count_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

/* hdl/ngram_record_parser.sv */
// Top level of the n-gram record parser: input byte register, parser core
// and result register. Depends on ngr_pkg and ngr_core.
`timescale 1ns / 1ps

// The parser takes one byte of a "<gram> <count>" record per clock while
// in_ready_o is high and gives one result when the byte flagged as end of
// record has been parsed. Each byte is held in an input register and folded
// into the parser state by the combinational update in ngr_core, so a rate
// of one byte per clock is sustained while no result stalls. The result
// register and out_valid_o are set as the end-of-record byte is parsed.
// Bytes that end no record keep flowing while a result waits to be taken; a
// second end-of-record byte waits in the input register until the output
// register is free. Write the order register (cfg_we_i, cfg_data_i) only
// while no record is in flight; the block does not enforce it. It resets to 4.

module ngram_record_parser #(
  parameter int unsigned MAX_ORDER       = 4,
  parameter int unsigned MAX_TOKEN_BYTES = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_record_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        count_clamped_o,
  output logic [3:0]  letters_o,
  output logic [18:0] gram_index_o,
  output logic [31:0] count_o
);

  logic                        s1_valid_q, s1_valid_d;
  logic [7:0]                  s1_byte_q;
  logic                        s1_eor_q;
  logic                        s1_go;
  logic                        in_accept;
  logic [2:0]                  gram_order_q;
  ngr_pkg::ngr_result_t        core_result;
  ngr_pkg::ngr_result_t        res_q;
  logic                        out_valid_q;

  assign s1_go      = s1_valid_q && (!s1_eor_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      gram_order_q <= 3'd4;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        gram_order_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_eor_q  <= end_of_record_i;
    end
  end

  ngr_core #(
    .MAX_ORDER       (MAX_ORDER),
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_go),
    .byte_i       (s1_byte_q),
    .eor_i        (s1_eor_q),
    .gram_order_i (gram_order_q),
    .result_o     (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_eor_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_eor_q) begin
      res_q <= core_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign count_clamped_o = res_q.count_clamped;
  assign letters_o       = res_q.letters;
  assign gram_index_o    = res_q.gram_index;
  assign count_o         = res_q.count;

endmodule

/* hdl/ngr_checker.sv */
// Port-level checks for the n-gram record parser, bound to its top level.
// Depends on ngram_record_parser and ngr_pkg status codes.
`timescale 1ns / 1ps

module ngr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        count_clamped_o,
  input logic [3:0]  letters_o,
  input logic [18:0] gram_index_o,
  input logic [31:0] count_o
);

  // A result that is not taken must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(count_o) && $stable(gram_index_o) && $stable(letters_o))
    else $error("stalled result changed");

  // Rejected for token or count: every other field is cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ngr_pkg::ST_TOKEN || status_o == ngr_pkg::ST_NOCOUNT)
    |-> count_o == '0 && !count_clamped_o && letters_o == '0 && gram_index_o == '0)
    else $error("fields not cleared on token or count rejection");

  // Only an accepted record carries an index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ngr_pkg::ST_OK |-> gram_index_o == '0)
    else $error("index given on a rejected record");

  // A clamped count is the saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_clamped_o |-> count_o == '1)
    else $error("clamp flag without saturated count");

endmodule

bind ngram_record_parser ngr_checker u_ngr_checker (.*);
